>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

>>> hdl/sgot_pkg.sv
// Package: constants and types of the stereo top-view block.
package sgot_pkg;
  localparam int TopSizeDef = 64;
  localparam int MaxDimDef  = 2048;
  localparam int DimW       = 12;
  localparam int RatioW     = 10;
  localparam int RowW       = 11;
  localparam int DispW      = 16;
  localparam int BinW       = 6;
  localparam int CntW       = 4;
  localparam logic [CntW-1:0] CountMax = 4'd13;

  typedef enum logic [1:0] {
    CfgRows  = 2'd0,
    CfgCols  = 2'd1,
    CfgRatio = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FuncPixel = 1'b0,
    FuncRead  = 1'b1
  } func_e;

  // Command handed from front to back.
  typedef struct packed {
    logic              rd;        // read-and-clear item
    logic              valid_pix; // nonzero disparity pixel
    logic              obst;      // classified obstacle
    logic [DispW-1:0]  raw;
    logic [RowW-1:0]   col;
    logic [DimW-1:0]   cols;
    logic [BinW-1:0]   bx;
    logic [BinW-1:0]   by;
    logic              rd_ok;     // read address in range
  } cmd_t;
endpackage

>>> hdl/sgot_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module sgot_divider import sgot_pkg::*; #(
  parameter int NumW = 32,
  parameter int DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int CntW2 = $clog2(NumW + 1);
  logic [NumW-1:0]  num_q, num_d;
  logic [DenW:0]    rem_q, rem_d;
  logic [DenW-1:0]  den_q;
  logic [CntW2-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DenW:0]    trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW2'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW2'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

>>> hdl/sgot_front.sv
// Front end: accepts items, classifies pixels against the ground plane.
module sgot_front import sgot_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [RowW-1:0]   pixel_row_i,
  input  logic [RowW-1:0]   pixel_col_i,
  input  logic [DispW-1:0]  disparity_i,
  input  logic [BinW-1:0]   bin_x_i,
  input  logic [BinW-1:0]   bin_y_i,
  input  logic [DimW-1:0]   rows_i,
  input  logic [DimW-1:0]   cols_i,
  input  logic [RatioW-1:0] ratio_i,
  input  logic              top_lim_ok_x_i,
  input  logic              top_lim_ok_y_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);
  // stage 1: capture item and form the two products
  logic        s1_q;
  cmd_t        c1_q;
  logic [27:0] lhs_q;   // raw * rows
  logic [26:0] rhs_q;   // ratio * lift (x16 applied at compare)
  logic        lift_ok_q;
  logic [12:0] lift;
  logic        s2_q;
  cmd_t        c2_q;
  cmd_t        c1_cls;
  logic        adv2;

  assign adv2       = !s2_q || cmd_ready_i;
  assign in_ready_o = !s1_q || adv2;
  assign lift       = {1'b0, pixel_row_i, 1'b0} - {1'b0, rows_i};

  // stage 2 command with the obstacle compare filled in
  always_comb begin
    c1_cls      = c1_q;
    c1_cls.obst = c1_q.valid_pix && lift_ok_q && (32'(lhs_q) > {1'b0, rhs_q, 4'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_q <= in_valid_i;
      if (adv2) s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      c1_q.rd        <= (func_i == FuncRead);
      c1_q.valid_pix <= (disparity_i != '0);
      c1_q.obst      <= 1'b0;
      c1_q.raw       <= disparity_i;
      c1_q.col       <= pixel_col_i;
      c1_q.cols      <= (cols_i == '0) ? DimW'(1) : cols_i;
      c1_q.bx        <= bin_x_i;
      c1_q.by        <= bin_y_i;
      c1_q.rd_ok     <= top_lim_ok_x_i && top_lim_ok_y_i;
      lhs_q          <= 28'(disparity_i) * 28'(rows_i);
      lift_ok_q      <= !lift[12];
      rhs_q          <= 27'(ratio_i) * 27'(lift[11:0]);
    end
    // stage 2: compare
    if (adv2 && s1_q) c2_q <= c1_cls;
  end

  assign cmd_valid_o = s2_q;
  assign cmd_o       = c2_q;
endmodule

>>> hdl/sgot_fifo.sv
// Small queue between front and back end.
module sgot_fifo import sgot_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

>>> hdl/sgot_back.sv
// Back end: divisions, bin placement, top-view store update and readout.
module sgot_back import sgot_pkg::*; #(
  parameter int TopSize = TopSizeDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              clr_busy_o,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       depth_word_o,
  output logic [7:0]        obstacle_depth_o,
  output logic              is_obstacle_o,
  output logic [BinW-1:0]   hit_x_o,
  output logic [BinW-1:0]   hit_y_o,
  output logic [7:0]        bin_value_o
);
  localparam int TW    = $clog2(TopSize);
  localparam int Cells = TopSize * TopSize;
  localparam int AW    = 2 * TW;
  localparam int XNumW = 25;

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StDivW  = 9'b000000100,
    StDivO  = 9'b000001000,
    StDivY  = 9'b000010000,
    StDivX  = 9'b000100000,
    StRead  = 9'b001000000,
    StWrite = 9'b010000000,
    StOut   = 9'b100000000
  } st_e;

  st_e             st_q, st_d;
  cmd_t            c_q;
  logic [AW-1:0]   clr_q;
  logic [CntW-1:0] mem [Cells];
  logic [CntW-1:0] rdat_q;
  logic [AW-1:0]   addr_q;
  logic [16:0]     dw_q;
  logic [11:0]     od_q;
  logic [12:0]     y_q;
  logic [XNumW-1:0] x_q;
  logic            xneg_q;

  // shared divider
  logic             dstart;
  logic [XNumW-1:0] dnum;
  logic [DispW-1:0] dden;
  logic             dbusy, ddone;
  logic [XNumW-1:0] dquo;

  sgot_divider #(.NumW(XNumW), .DenW(DispW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .busy_o(dbusy), .done_o(ddone), .quo_o(dquo)
  );

  // x numerator: (cols/2 - col)*TOP + TOP/2*cols, signed
  logic signed [XNumW:0] xnum;
  assign xnum = ($signed({2'b0, c_q.cols[DimW-1:1]}) - $signed({3'b0, c_q.col}))
                * $signed((XNumW+1)'(TopSize))
                + $signed((XNumW+1)'(TopSize / 2)) * $signed({14'b0, c_q.cols});

  always_comb begin
    dstart = 1'b0;
    dnum   = '0;
    dden   = c_q.raw;
    st_d   = st_q;
    case (st_q)
      StClear: if (clr_q == AW'(Cells-1)) st_d = StIdle;
      StIdle: if (cmd_valid_i) st_d = StDivW;
      StDivW: begin
        if (!c_q.valid_pix || c_q.rd) st_d = c_q.rd ? StRead : StOut;
        else if (!dbusy && !ddone) begin
          dstart = 1'b1;
          dnum   = XNumW'(131072) + XNumW'(c_q.raw[15:1]);
        end else if (ddone) st_d = c_q.obst ? StDivO : StOut;
      end
      StDivO: begin
        if (!dbusy && !ddone) begin
          dstart = 1'b1;
          dnum   = XNumW'(1600) + XNumW'(c_q.raw[15:1]);
        end else if (ddone) st_d = StDivY;
      end
      StDivY: begin
        if (!dbusy && !ddone) begin
          dstart = 1'b1;
          dnum   = XNumW'(4096);
        end else if (ddone) st_d = StDivX;
      end
      StDivX: begin
        dden = DispW'(c_q.cols);
        if (xneg_q) st_d = StRead;
        else if (!dbusy && !ddone) begin
          dstart = 1'b1;
          dnum   = xnum[XNumW-1:0];
        end else if (ddone) st_d = StRead;
      end
      StRead:  st_d = StWrite;
      StWrite: st_d = StOut;
      StOut:   if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign cmd_ready_o = (st_q == StIdle);
  assign clr_busy_o  = (st_q == StClear);

  // bin placement from quotients
  logic [TW-1:0] xb, yb;
  assign yb = (y_q > 13'(TopSize-1)) ? TW'(TopSize-1) : y_q[TW-1:0];
  assign xb = xneg_q ? '0 :
              (x_q > XNumW'(TopSize-1)) ? TW'(TopSize-1) : x_q[TW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StClear;
      clr_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i) begin
      c_q  <= cmd_i;
      dw_q <= '0;
      od_q <= '0;
      y_q  <= '0;
      x_q  <= '0;
    end
    if (st_q == StDivO && dstart) xneg_q <= xnum[XNumW];
    if (ddone) begin
      case (st_q)
        StDivW:  dw_q <= (dquo > XNumW'(65535)) ? 17'd65535 : dquo[16:0];
        StDivO:  od_q <= (dquo > XNumW'(255)) ? 12'd255 : dquo[11:0];
        StDivY:  y_q  <= dquo[12:0];
        StDivX:  x_q  <= dquo;
        default: ;
      endcase
    end
    // store address, read cycle
    if (st_q == StRead) begin
      addr_q <= c_q.rd ? {c_q.by[TW-1:0], c_q.bx[TW-1:0]} : {yb, xb};
      rdat_q <= c_q.rd ? mem[{c_q.by[TW-1:0], c_q.bx[TW-1:0]}] : mem[{yb, xb}];
    end
    // store write: clear pass, read-clear or saturating increment
    if (st_q == StClear) mem[clr_q] <= '0;
    else if (st_q == StWrite && (!c_q.rd || c_q.rd_ok))
      mem[addr_q] <= c_q.rd ? '0 : ((rdat_q < CountMax) ? rdat_q + 1'b1 : rdat_q);
  end

  logic [8:0] bv;
  assign bv = 9'(rdat_q) * 9'd20;

  assign out_valid_o      = (st_q == StOut);
  assign depth_word_o     = dw_q[15:0];
  assign obstacle_depth_o = c_q.obst ? od_q[7:0] : 8'd0;
  assign is_obstacle_o    = !c_q.rd && c_q.obst;
  assign hit_x_o          = is_obstacle_o ? BinW'(xb) : '0;
  assign hit_y_o          = is_obstacle_o ? BinW'(yb) : '0;
  assign bin_value_o      = (c_q.rd && c_q.rd_ok) ? (bv > 9'd255 ? 8'd255 : bv[7:0]) : 8'd0;
endmodule

>>> hdl/stereo_ground_obstacle_topview.sv
// Top level: stereo ground / obstacle split with top-view histogram.
//   Channel | Handshake              | Payload
//   cfg     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//   in      | in_valid_i/in_ready_o  | func, row, col, disparity, bin x/y
//   out     | out_valid_o/out_ready_i| depth, obstacle, hit, bin value
// Each division (start, 25 steps, done) runs on one shared divider. The back
// end takes one item at a time: an obstacle pixel uses up to four divisions,
// a ground pixel one, an invalid pixel and a bin read none; with any output stall,
// it sets the rate. After reset a clearing pass zeroes all TOP_SIZE*TOP_SIZE
// cells of the store; no item is accepted then. A front pipe and a two-entry
// queue decouple input from the back end, which holds its result until taken.
module stereo_ground_obstacle_topview import sgot_pkg::*; #(
  parameter int TOP_SIZE = TopSizeDef,
  parameter int MAX_DIM  = MaxDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [DimW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [RowW-1:0]   pixel_row_i,
  input  logic [RowW-1:0]   pixel_col_i,
  input  logic [DispW-1:0]  disparity_i,
  input  logic [BinW-1:0]   bin_x_i,
  input  logic [BinW-1:0]   bin_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       depth_word_o,
  output logic [7:0]        obstacle_depth_o,
  output logic              is_obstacle_o,
  output logic [BinW-1:0]   hit_x_o,
  output logic [BinW-1:0]   hit_y_o,
  output logic [7:0]        bin_value_o
);
  logic [DimW-1:0]   rows_q, cols_q, dimv;
  logic [RatioW-1:0] ratio_q;
  logic              fr_ready, clr_busy;
  logic              f_valid, f_ready, q_valid, q_ready;
  cmd_t              f_cmd, q_cmd;

  // configuration registers, dimensions clamped
  assign dimv = (cfg_wdata_i > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : cfg_wdata_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 12'd480;
      cols_q  <= 12'd640;
      ratio_q <= 10'd200;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRows:  rows_q  <= dimv;
        CfgCols:  cols_q  <= dimv;
        CfgRatio: ratio_q <= cfg_wdata_i[RatioW-1:0];
        default:  ;
      endcase
    end
  end

  assign in_ready_o = fr_ready && !clr_busy;

  sgot_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i && !clr_busy), .in_ready_o(fr_ready),
    .func_i, .pixel_row_i, .pixel_col_i, .disparity_i, .bin_x_i, .bin_y_i,
    .rows_i(rows_q), .cols_i(cols_q), .ratio_i(ratio_q),
    .top_lim_ok_x_i(7'(bin_x_i) < 7'(TOP_SIZE)),
    .top_lim_ok_y_i(7'(bin_y_i) < 7'(TOP_SIZE)),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  sgot_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  sgot_back #(.TopSize(TOP_SIZE)) u_back (
    .clk_i, .rst_ni, .clr_busy_o(clr_busy),
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .depth_word_o, .obstacle_depth_o, .is_obstacle_o,
    .hit_x_o, .hit_y_o, .bin_value_o
  );
endmodule

>>> hdl/sgot_checker.sv
// Port-level checker for the top level, with its bind.
`include "assert_macros.svh"
module sgot_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_obstacle_o,
  input logic [7:0]  obstacle_depth_o,
  input logic [5:0]  hit_x_o,
  input logic [5:0]  hit_y_o,
  input logic [7:0]  bin_value_o,
  input logic [15:0] depth_word_o
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(depth_word_o), "output dropped while stalled")
  `ASSERT_IMPL(a_hit_zero, clk_i, rst_ni, out_valid_o && !is_obstacle_o, hit_x_o == 6'd0 && hit_y_o == 6'd0 && obstacle_depth_o == 8'd0, "hit without obstacle")
  `ASSERT_IMPL(a_bin_excl, clk_i, rst_ni, out_valid_o && bin_value_o != 8'd0, depth_word_o == 16'd0 && !is_obstacle_o, "read mixed with pixel")
endmodule

bind stereo_ground_obstacle_topview sgot_checker u_chk (.*);

>>> tb/testbench.sv
// Testbench of the stereo ground / obstacle top-view block.
`timescale 1ns / 100ps

// Checks each depth / obstacle / bin result against a predictor of the block.
class depth_scoreboard;
  typedef struct packed {
    logic [15:0] depth_word;
    logic [7:0]  obstacle_depth;
    logic        is_obstacle;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [7:0]  bin_value;
  } depth_res_t;

  logic [3:0]  bin_counts [4096];
  logic [11:0] rows_reg;
  logic [11:0] cols_reg;
  logic [9:0]  ratio_reg;
  depth_res_t  pending_results [$];
  int          mismatches;
  int          checked;
  int          obstacle_hits;
  int          bin_reads;

  function new();
    foreach (bin_counts[i]) bin_counts[i] = '0;
    rows_reg      = 12'd480;
    cols_reg      = 12'd640;
    ratio_reg     = 10'd200;
    mismatches    = 0;
    checked       = 0;
    obstacle_hits = 0;
    bin_reads     = 0;
  endfunction

  function void write_reg(sgot_pkg::cfg_idx_e idx, logic [11:0] val);
    logic [11:0] dim;
    dim = (val > 12'd2048) ? 12'd2048 : val;
    case (idx)
      sgot_pkg::CfgRows:  rows_reg = dim;
      sgot_pkg::CfgCols:  cols_reg = dim;
      sgot_pkg::CfgRatio: ratio_reg = val[9:0];
      default: ;
    endcase
  endfunction

  // Predict the result of one accepted input transfer.
  function void note_input(logic func, logic [10:0] row, logic [10:0] col,
                           logic [15:0] disp, logic [5:0] bx, logic [5:0] by);
    depth_res_t r;
    longint     raw, nrows, ncols, lift, num, x, y, od, dw;
    int         idx;
    r = '0;
    raw = disp;
    if (func == sgot_pkg::FuncRead) begin
      idx = by * 64 + bx;
      r.bin_value = (20 * bin_counts[idx] > 255) ? 8'd255 : 8'(20 * bin_counts[idx]);
      bin_counts[idx] = '0;
      bin_reads++;
    end else if (raw != 0) begin
      dw = (131072 + raw / 2) / raw;
      r.depth_word = (dw > 65535) ? 16'hFFFF : 16'(dw);
      nrows = rows_reg;
      ncols = (cols_reg == 0) ? 1 : cols_reg;
      lift = 2 * longint'(row) - nrows;
      if (lift >= 0 && raw * nrows > 16 * longint'(ratio_reg) * lift) begin
        od = (1600 + raw / 2) / raw;
        if (od > 255) od = 255;
        y = 4096 / raw;
        if (y > 63) y = 63;
        num = (ncols / 2 - longint'(col)) * 64 + 32 * ncols;
        x = (num < 0) ? 0 : num / ncols;
        if (x > 63) x = 63;
        idx = int'(y * 64 + x);
        if (bin_counts[idx] < sgot_pkg::CountMax) bin_counts[idx]++;
        r.obstacle_depth = 8'(od);
        r.is_obstacle    = 1'b1;
        r.hit_x          = 6'(x);
        r.hit_y          = 6'(y);
        obstacle_hits++;
      end
    end
    pending_results.push_back(r);
  endfunction

  // Compare one output transfer against the oldest prediction.
  function void check_result(depth_res_t act);
    depth_res_t exp_r;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", act);
      return;
    end
    exp_r = pending_results.pop_front();
    checked++;
    if (act !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch #%0d: exp dw=%0d od=%0d ob=%0b x=%0d y=%0d bv=%0d",
                 checked, exp_r.depth_word, exp_r.obstacle_depth, exp_r.is_obstacle,
                 exp_r.hit_x, exp_r.hit_y, exp_r.bin_value);
        $display("  got dw=%0d od=%0d ob=%0b x=%0d y=%0d bv=%0d",
                 act.depth_word, act.obstacle_depth, act.is_obstacle, act.hit_x,
                 act.hit_y, act.bin_value);
      end
    end
  endfunction
endclass

module testbench;
  import sgot_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [11:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [10:0] pixel_row_i;
  logic [10:0] pixel_col_i;
  logic [15:0] disparity_i;
  logic [5:0]  bin_x_i;
  logic [5:0]  bin_y_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] depth_word_o;
  logic [7:0]  obstacle_depth_o;
  logic        is_obstacle_o;
  logic [5:0]  hit_x_o;
  logic [5:0]  hit_y_o;
  logic [7:0]  bin_value_o;

  depth_scoreboard depth_sb;
  int  sent_items;
  bit  hold_off;

  stereo_ground_obstacle_topview DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      depth_sb.note_input(func_i, pixel_row_i, pixel_col_i, disparity_i, bin_x_i, bin_y_i);
    if (rst_ni && out_valid_o && out_ready_i)
      depth_sb.check_result({depth_word_o, obstacle_depth_o, is_obstacle_o,
                             hit_x_o, hit_y_o, bin_value_o});
  end

  // Receiver stall pattern, with a long hold-off when requested.
  initial begin
    int phase;
    out_ready_i = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off) out_ready_i <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(logic func, logic [10:0] row, logic [10:0] col,
                           logic [15:0] disp, logic [5:0] bx, logic [5:0] by);
    in_valid_i  <= 1'b1;
    func_i      <= func;
    pixel_row_i <= row;
    pixel_col_i <= col;
    disparity_i <= disp;
    bin_x_i     <= bx;
    bin_y_i     <= by;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // One register write, then a quiet gap with the write enable low before the task returns.
  task automatic write_reg(cfg_idx_e idx, logic [11:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    depth_sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until all results are in, plus latency margin.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (depth_sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Random pixel: mostly bottom-half rows and small disparity so obstacles occur.
  task automatic random_pixel(int rows, int cols);
    logic [10:0] row, col;
    logic [15:0] disp;
    case ($urandom_range(0, 9))
      0: disp = 16'($urandom);
      1: disp = 16'd0;
      2, 3: disp = 16'($urandom_range(1, 300));
      default: disp = 16'($urandom_range(1, 4000));
    endcase
    if ($urandom_range(0, 7) == 0) row = 11'($urandom);
    else row = 11'($urandom_range(rows / 2, (rows > 2047) ? 2047 : rows));
    if ($urandom_range(0, 7) == 0) col = 11'($urandom);
    else col = 11'($urandom_range(0, (cols > 2047) ? 2047 : cols));
    send_item(FuncPixel, row, col, disp, 6'($urandom), 6'($urandom));
  endtask

  task automatic random_phase(int n, int rows, int cols);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if (n > 0) begin
          if ($urandom_range(0, 5) == 0)
            send_item(FuncRead, 11'($urandom), 11'($urandom), 16'($urandom),
                      6'($urandom), 6'($urandom));
          else random_pixel(rows, cols);
          n--;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgRows;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = FuncPixel;
    pixel_row_i = '0;
    pixel_col_i = '0;
    disparity_i = '0;
    bin_x_i     = '0;
    bin_y_i     = '0;
    hold_off    = 1'b0;
    sent_items  = 0;
    depth_sb    = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, invalid disparity, reads, saturation.
    send_item(FuncPixel, 11'd479, 11'd0, 16'd0, 6'd0, 6'd0);
    send_item(FuncPixel, 11'd479, 11'd0, 16'd1, 6'd0, 6'd0);
    send_item(FuncPixel, 11'd2047, 11'd2047, 16'hFFFF, 6'd63, 6'd63);
    send_item(FuncPixel, 11'd0, 11'd320, 16'd2, 6'd0, 6'd0);
    send_item(FuncPixel, 11'd240, 11'd320, 16'd64, 6'd0, 6'd0);
    send_item(FuncPixel, 11'd300, 11'd639, 16'd3, 6'd0, 6'd0);
    repeat (15) send_item(FuncPixel, 11'd470, 11'd100, 16'd100, 6'd0, 6'd0);
    send_item(FuncRead, 11'd2047, 11'd2047, 16'hFFFF, 6'd0, 6'd0);
    send_item(FuncRead, 11'd0, 11'd0, 16'd0, 6'd22, 6'd40);
    send_item(FuncRead, 11'd0, 11'd0, 16'd0, 6'd22, 6'd40);
    send_item(FuncRead, 11'd0, 11'd0, 16'd0, 6'd63, 6'd63);
    drain();

    random_phase(200, 480, 640);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40, 480, 640);
    join
    drain();

    write_reg(CfgRows, 12'd2);
    write_reg(CfgCols, 12'd2);
    write_reg(CfgRatio, 12'd0);
    random_phase(150, 2, 2);
    drain();

    write_reg(CfgRows, 12'hFFF);
    write_reg(CfgCols, 12'hFFF);
    write_reg(CfgRatio, 12'h3FF);
    random_phase(150, 2048, 2048);
    drain();

    write_reg(CfgRows, 12'd0);
    write_reg(CfgCols, 12'd0);
    write_reg(CfgRatio, 12'h155);
    random_phase(80, 0, 0);
    drain();

    write_reg(CfgRows, 12'd64);
    write_reg(CfgCols, 12'd100);
    write_reg(CfgRatio, 12'd20);
    random_phase(200, 64, 100);
    drain();

    $display("%0d items sent, %0d results checked, %0d obstacle hits, %0d bin reads",
             sent_items, depth_sb.checked, depth_sb.obstacle_hits, depth_sb.bin_reads);
    $display("mismatches: %0d", depth_sb.mismatches);
    if (depth_sb.mismatches == 0 && depth_sb.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
